[hw/rtl/ialu_pkg.sv]
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants for the 64-bit integer ALU
// Operation codes and the control record that moves down the cell chain.
// ----------------------------------------------------------------------------
package ialu_pkg;

    // Default operand width.
    localparam int DataWidthDefault = 64;

    // Operation codes of the kind field.
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_AND  = 4'd2,
        OP_OR   = 4'd3,
        OP_XOR  = 4'd4,
        OP_NOT  = 4'd5,
        OP_INC  = 4'd6,
        OP_SHL  = 4'd7,
        OP_SHR  = 4'd8,
        OP_MUL  = 4'd9,
        OP_DIV  = 4'd10,
        OP_MOD  = 4'd11,
        OP_MOV  = 4'd12,
        OP_EQ   = 4'd13,
        OP_ZERO = 4'd14,
        OP_CLR  = 4'd15
    } kind_t;

    // Control and flag record carried alongside the operand words.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  carry;
        logic  err;
        logic  cond;
        logic  hinz;
    } ctl_t;

endpackage

[hw/rtl/integer_alu_64bit_core.sv]
// ----------------------------------------------------------------------------
// integer_alu_64bit_core: unsigned integer ALU with multiply and divide
// Entry stage, a chain of one-bit multiply/divide cells, and a result stage.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Transfer
//  command   start, busy, kind, operand_a/b        start high, busy low
//  result    done, result_value, remainder_value,  done high for one cycle
//            carry_flag, divide_error, condition_bit
//
// Every operation passes from start to done through one entry stage, one
// cell per operand bit for the multiply and divide steps, and one result
// stage. A new command is taken every cycle; busy is always low.
// Reset clears the valid bits of every stage; results cannot be stalled.
// ----------------------------------------------------------------------------
module integer_alu_64bit_core #(
    parameter int DATA_WIDTH = ialu_pkg::DataWidthDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ialu_pkg::kind_t       kind,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic [DATA_WIDTH-1:0] remainder_value,
    output logic                  carry_flag,
    output logic                  divide_error,
    output logic                  condition_bit
);
    import ialu_pkg::*;

    localparam int Latency = DATA_WIDTH + 2;

    ctl_t                  ctl_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] a_s   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] b_s   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] acc_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_s [0:DATA_WIDTH];

    // The pipeline never holds off a command.
    assign busy = 1'b0;

    // Entry stage.
    ialu_front #(.W(DATA_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctl_out   (ctl_s[0]),
        .a_out     (a_s[0]),
        .b_out     (b_s[0]),
        .acc_out   (acc_s[0])
    );
    assign rem_s[0] = '0;

    // Cell chain, multiplier bits taken from bit 0 upwards.
    for (genvar g = 0; g < DATA_WIDTH; g++)
    begin : g_cell
        ialu_cell #(.W(DATA_WIDTH), .IDX(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_s[g]),
            .a_in    (a_s[g]),
            .b_in    (b_s[g]),
            .acc_in  (acc_s[g]),
            .rem_in  (rem_s[g]),
            .ctl_out (ctl_s[g+1]),
            .a_out   (a_s[g+1]),
            .b_out   (b_s[g+1]),
            .acc_out (acc_s[g+1]),
            .rem_out (rem_s[g+1])
        );
    end

    // Result stage.
    ialu_back #(.W(DATA_WIDTH)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl_in          (ctl_s[DATA_WIDTH]),
        .a_in            (a_s[DATA_WIDTH]),
        .acc_in          (acc_s[DATA_WIDTH]),
        .rem_in          (rem_s[DATA_WIDTH]),
        .done            (done),
        .result_value    (result_value),
        .remainder_value (remainder_value),
        .carry_flag      (carry_flag),
        .divide_error    (divide_error),
        .condition_bit   (condition_bit)
    );

`ifndef ASSERT_OFF
    // Every accepted command yields its result after the fixed latency.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##Latency done)
        else $error("result missing after command transfer");

    // No result appears without a command the fixed latency earlier.
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Latency))
        else $error("result without a command");

    // A divide error leaves both value fields at zero.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_error) |-> (result_value == '0 && remainder_value == '0))
        else $error("divide error with nonzero value");

    // The condition bit never comes with a carry or a divide error.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && condition_bit) |-> (!carry_flag && !divide_error))
        else $error("condition bit with another flag");
`endif

endmodule

[hw/rtl/ialu_front.sv]
// ----------------------------------------------------------------------------
// ialu_front: entry stage of the ALU
// Registers each transfer and works out the operations that need no cell step.
// ----------------------------------------------------------------------------
module ialu_front #(
    parameter int W = ialu_pkg::DataWidthDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ialu_pkg::kind_t      kind,
    input  logic [W-1:0]         operand_a,
    input  logic [W-1:0]         operand_b,
    output ialu_pkg::ctl_t       ctl_out,
    output logic [W-1:0]         a_out,
    output logic [W-1:0]         b_out,
    output logic [W-1:0]         acc_out
);
    import ialu_pkg::*;

    ctl_t         ctl_reg, ctl_next;
    logic [W-1:0] a_reg, b_reg, acc_reg, acc_next;
    logic [W:0]   sum_ab, sum_inc;

    // Separate adders for add and increment.
    assign sum_ab  = {1'b0, operand_a} + {1'b0, operand_b};
    assign sum_inc = {1'b0, operand_a} + {{W{1'b0}}, 1'b1};

    // Operations that need no cell step, and initial flags.
    always_comb
    begin
        ctl_next       = '0;
        ctl_next.valid = start;
        ctl_next.kind  = kind;
        acc_next       = '0;
        unique case (kind)
            OP_ADD:
            begin
                acc_next       = sum_ab[W-1:0];
                ctl_next.carry = sum_ab[W];
            end
            OP_SUB:
            begin
                acc_next       = operand_a - operand_b;
                ctl_next.carry = (operand_a < operand_b);
            end
            OP_AND:  acc_next = operand_a & operand_b;
            OP_OR:   acc_next = operand_a | operand_b;
            OP_XOR:  acc_next = operand_a ^ operand_b;
            OP_NOT:  acc_next = ~operand_a;
            OP_INC:
            begin
                acc_next       = sum_inc[W-1:0];
                ctl_next.carry = sum_inc[W];
            end
            OP_SHL:  acc_next = {operand_a[W-2:0], 1'b0};
            OP_SHR:  acc_next = {1'b0, operand_a[W-1:1]};
            OP_MOV:  acc_next = operand_a;
            OP_EQ:   ctl_next.cond = (operand_a == operand_b);
            OP_ZERO: ctl_next.cond = (operand_a == '0);
            OP_DIV, OP_MOD: ctl_next.err = (operand_b == '0);
            default: acc_next = '0;
        endcase
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        a_reg   <= operand_a;
        b_reg   <= operand_b;
        acc_reg <= acc_next;
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign acc_out = acc_reg;

endmodule

[hw/rtl/ialu_cell.sv]
// ----------------------------------------------------------------------------
// ialu_cell: one bit step of multiply and divide
// Does one shift-and-add step of the product or one restoring divide step.
// ----------------------------------------------------------------------------
module ialu_cell #(
    parameter int W   = ialu_pkg::DataWidthDefault,
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ialu_pkg::ctl_t       ctl_in,
    input  logic [W-1:0]         a_in,
    input  logic [W-1:0]         b_in,
    input  logic [W-1:0]         acc_in,
    input  logic [W-1:0]         rem_in,
    output ialu_pkg::ctl_t       ctl_out,
    output logic [W-1:0]         a_out,
    output logic [W-1:0]         b_out,
    output logic [W-1:0]         acc_out,
    output logic [W-1:0]         rem_out
);
    import ialu_pkg::*;

    ctl_t         ctl_reg, ctl_next;
    logic [W-1:0] a_reg, b_reg, acc_reg, rem_reg;
    logic [W-1:0] a_next, acc_next, rem_next;
    logic [W:0]   prod_sum;
    logic [W:0]   rem_sh;
    logic [W+1:0] diff;
    logic         ge;

    // Partial product add and trial subtraction.
    assign prod_sum = {1'b0, acc_in} + {1'b0, a_in};
    assign rem_sh   = {rem_in, a_in[W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, b_in};
    assign ge       = ~diff[W+1];

    // Step selection by operation.
    always_comb
    begin
        ctl_next = ctl_in;
        a_next   = a_in;
        acc_next = acc_in;
        rem_next = rem_in;
        case (ctl_in.kind)
            OP_MUL:
            begin
                if (b_in[IDX])
                begin
                    acc_next       = prod_sum[W-1:0];
                    ctl_next.carry = ctl_in.carry | prod_sum[W] | ctl_in.hinz;
                end
                a_next        = {a_in[W-2:0], 1'b0};
                ctl_next.hinz = ctl_in.hinz | a_in[W-1];
            end
            OP_DIV, OP_MOD:
            begin
                rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
                a_next   = {a_in[W-2:0], ge};
            end
            default: ctl_next = ctl_in;
        endcase
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_in;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign acc_out = acc_reg;
    assign rem_out = rem_reg;

endmodule

[hw/rtl/ialu_back.sv]
// ----------------------------------------------------------------------------
// ialu_back: result stage of the ALU
// Picks the final fields from the end of the chain and registers them.
// ----------------------------------------------------------------------------
module ialu_back #(
    parameter int W = ialu_pkg::DataWidthDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ialu_pkg::ctl_t       ctl_in,
    input  logic [W-1:0]         a_in,
    input  logic [W-1:0]         acc_in,
    input  logic [W-1:0]         rem_in,
    output logic                 done,
    output logic [W-1:0]         result_value,
    output logic [W-1:0]         remainder_value,
    output logic                 carry_flag,
    output logic                 divide_error,
    output logic                 condition_bit
);
    import ialu_pkg::*;

    logic         done_reg;
    logic [W-1:0] res_reg, res_next, rem_reg, rem_next;
    logic         carry_reg, err_reg, cond_reg;

    // Final selection; a zero divisor forces zeros.
    always_comb
    begin
        res_next = acc_in;
        rem_next = '0;
        case (ctl_in.kind)
            OP_DIV:
            begin
                res_next = ctl_in.err ? '0 : a_in;
                rem_next = ctl_in.err ? '0 : rem_in;
            end
            OP_MOD:
            begin
                res_next = ctl_in.err ? '0 : rem_in;
                rem_next = ctl_in.err ? '0 : rem_in;
            end
            default: res_next = acc_in;
        endcase
    end

    // Strobe register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_in.valid;
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        rem_reg   <= rem_next;
        carry_reg <= ctl_in.carry;
        err_reg   <= ctl_in.err;
        cond_reg  <= ctl_in.cond;
    end

    assign done            = done_reg;
    assign result_value    = res_reg;
    assign remainder_value = rem_reg;
    assign carry_flag      = carry_reg;
    assign divide_error    = err_reg;
    assign condition_bit   = cond_reg;

endmodule
